### design/kmps_pkg.sv
// Shared types and constants for the streaming KMP matcher.
package kmps_pkg;

  localparam int MAX_PATTERN_DEF   = 32;
  localparam int POSITION_BITS_DEF = 32;
  localparam int NUM_PAT_REGS      = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int START_W           = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd4;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       advance;
    logic       clear;
    logic [7:0] text_char;
  } cell_ctl_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
  } result_t;

endpackage

### design/kmps_cell.sv
// One matcher cell: a pattern byte and the "prefix of length IDX+1 matched" bit.
module kmps_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  kmps_pkg::cfg_wr_t   cfg,
  input  kmps_pkg::cell_ctl_t ctl,
  input  logic                link_in,
  output logic                hit_next,
  output logic                state_q
);

  localparam int LANE = IDX % 8;
  localparam int REG  = IDX / 8;

  logic [7:0] pat_char;

  generate
    if (REG < kmps_pkg::NUM_PAT_REGS) begin : g_byte
      logic [7:0] pat_reg;
      always_ff @(posedge clk) begin
        if (rst) begin
          pat_reg <= 8'h00;
        end else if (cfg.en && cfg.index == kmps_pkg::CFG_IDX_W'(REG)) begin
          pat_reg <= cfg.data[8*LANE +: 8];
        end
      end
      assign pat_char = pat_reg;
    end else begin : g_zero
      // beyond the pattern registers the byte reads as zero
      assign pat_char = 8'h00;
    end
  endgenerate

  assign hit_next = link_in && (pat_char == ctl.text_char);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      state_q <= 1'b0;
    end else if (ctl.advance) begin
      state_q <= hit_next;
    end
  end

endmodule

### design/kmps_skid.sv
// Two-entry output buffer: output register plus skid register.
module kmps_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kmps_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output kmps_pkg::result_t out_data
);

  logic              skid_valid;
  kmps_pkg::result_t skid_data;
  logic              take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

### design/kmp_stream_matcher.sv
// Top level of the streaming KMP matcher: cell row, length, position, output buffer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_stall  | text_byte[7:0], new_text
//  out     | output    | out_valid/out_stall  | match_found, match_start[31:0]
//  cfg     | input     | cfg_write            | cfg_index[2:0], cfg_data[63:0]
//
// One text word is taken per cycle, the rate of the cell row, while in_stall is
// low; its result goes to the output register, or to the skid entry while held.
// Each cell compares pattern and text byte and passes its bit to its neighbor.
// rst (synchronous) clears the cells, position, pattern (all zero) and length (1).
// in_stall rises only when both the output register and the skid entry are full.
// A config write to a valid index clears the match bits; the position is kept.
//
// Cell i holds "the last i+1 text bytes equal pattern bytes 0..i". This set of
// bits is the full set of borders KMP walks through its failure table, so the
// match flag equals the KMP result and no table has to be built.
module kmp_stream_matcher #(
  parameter int MAX_PATTERN   = kmps_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = kmps_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [kmps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kmps_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            text_byte,
  input  logic                                  new_text,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  match_found,
  output logic [kmps_pkg::START_W-1:0]          match_start
);

  localparam int SEL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  kmps_pkg::cfg_wr_t   cfg;
  kmps_pkg::cell_ctl_t ctl;
  kmps_pkg::result_t   res;
  kmps_pkg::result_t   out_data;

  logic                     accept;
  logic                     cfg_clear;
  logic [MAX_PATTERN-1:0]   link;
  logic [MAX_PATTERN-1:0]   hit_vec;
  logic [MAX_PATTERN-1:0]   cell_state;
  logic [SEL_W-1:0]         last_cell;       // active length minus one
  logic [POSITION_BITS-1:0] text_position;
  logic [POSITION_BITS-1:0] pos_base;
  logic [POSITION_BITS-1:0] start_full;
  logic [6:0]               len_req;

  assign accept    = in_valid && !in_stall;
  assign cfg       = '{en: cfg_write, index: cfg_index, data: cfg_data};
  assign cfg_clear = cfg_write && (cfg_index <= kmps_pkg::REG_LENGTH);

  assign ctl = '{advance: accept, clear: cfg_clear, text_char: text_byte};

  // new_text drops every partial match before the byte is compared
  always_comb begin
    link[0] = 1'b1;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      link[i] = cell_state[i-1] && !new_text;
    end
  end

  generate
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
      kmps_cell #(.IDX(g)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cfg      (cfg),
        .ctl      (ctl),
        .link_in  (link[g]),
        .hit_next (hit_vec[g]),
        .state_q  (cell_state[g])
      );
    end
  endgenerate

  // Length register, clamped to 1..MAX_PATTERN on write
  assign len_req = {1'b0, cfg_data[5:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_cell <= '0;
    end else if (cfg_write && cfg_index == kmps_pkg::REG_LENGTH) begin
      if (len_req == 7'd0) begin
        last_cell <= '0;
      end else if (len_req > 7'(MAX_PATTERN)) begin
        last_cell <= SEL_W'(MAX_PATTERN - 1);
      end else begin
        last_cell <= SEL_W'(len_req - 7'd1);
      end
    end
  end

  // Text position: index of the next byte, wraps
  assign pos_base = new_text ? '0 : text_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
    end else if (accept) begin
      text_position <= pos_base + POSITION_BITS'(1);
    end
  end

  // start = position - length + 1 = position - last_cell
  assign start_full = pos_base - POSITION_BITS'(last_cell);
  assign res.found  = hit_vec[last_cell];
  assign res.start  = res.found ? kmps_pkg::START_W'(start_full) : '0;

  kmps_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign match_found = out_data.found;
  assign match_start = out_data.start;

  // The skid entry only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry full while output register empty");

  // A word taken while the output is held fills the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && out_stall) |=> in_stall)
    else $error("word accepted under stall was not buffered");

  // Position steps by one for each word in the same text.
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !new_text) |=> text_position == $past(text_position) + POSITION_BITS'(1))
    else $error("text position did not advance");

  // A pattern or length write drops all partial matches.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_clear |=> cell_state == '0)
    else $error("match bits survived a config write");

endmodule
